>>> rtl/ste_pkg.sv
// Shared constants, types and request/result records for the session table.
package ste_pkg;

	localparam int SLOTS      = 8;
	localparam int IW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int TOKEN_W    = 64;
	localparam int TIME_W     = 32;
	localparam int ROLE_W     = 2;
	localparam int FUNC_W     = 2;
	localparam int SLOT_IDX_W = 6;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1800000;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CREATE  = 2'd0,
		FUNC_CHECK   = 2'd1,
		FUNC_DESTROY = 2'd2
	} func_t;

	// One stored session; the valid bit lives outside the memory.
	typedef struct packed {
		logic [TOKEN_W-1:0] token_hi;
		logic [TOKEN_W-1:0] token_lo;
		logic [ROLE_W-1:0]  role;
		logic [TIME_W-1:0]  expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [TIME_W-1:0]  now;
		logic [TOKEN_W-1:0] token_hi;
		logic [TOKEN_W-1:0] token_lo;
		logic [ROLE_W-1:0]  new_role;
		logic [ROLE_W-1:0]  need_role;
	} req_t;

	typedef struct packed {
		logic [ROLE_W-1:0]     role_out;
		logic                  allowed;
		logic                  hit;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic                  evicted;
	} res_t;

endpackage

>>> rtl/ste_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ste_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ste_engine.sv
// Sequencer: scans every slot through the entry memory, then updates at most one slot.
module ste_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  ste_pkg::req_t            req,
	input  logic [ste_pkg::TIME_W-1:0] timeout,
	output logic                     res_valid,
	output ste_pkg::res_t            res,
	input  logic                     res_take
);
	import ste_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   issue_cnt_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [SLOTS-1:0]   slot_valid_q;
	logic               free_found_q;
	logic               min_found_q;
	logic               hit_q;
	logic               res_valid_q;
	res_t               res_q;

	req_t               req_q;
	logic [TIME_W-1:0]  fresh_q;
	logic [IW-1:0]      free_idx_q;
	logic [IW-1:0]      min_idx_q;
	logic [TIME_W-1:0]  min_exp_q;
	logic [IW-1:0]      m_idx_q;
	logic [TIME_W-1:0]  m_exp_q;
	logic [ROLE_W-1:0]  m_role_q;

	logic [ENTRY_W-1:0] rdata;
	entry_t             ent_rd;
	logic               accept;
	logic               issuing;
	logic               scan_proc;
	logic               is_create;
	logic               is_lookup;
	logic               cur_valid;
	logic               cur_expired;
	logic               cur_live;
	logic               take_free;
	logic               take_min;
	logic               take_match;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	entry_t             ram_wdata;
	logic               wr_set;
	logic               wr_clr;
	logic [IW-1:0]      wr_idx;
	res_t               res_d;
	logic [IW-1:0]      pick;
	logic               m_expired;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign issuing   = (state_q == ST_SCAN) && (issue_cnt_q < CNT_W'(SLOTS));
	assign scan_proc = (state_q == ST_SCAN) && rd_vld_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	ste_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (issue_cnt_q[IW-1:0]),
		.rdata (rdata)
	);

	// Per-slot evaluation of the entry that just came out of the memory.
	always_comb begin
		ent_rd      = entry_t'(rdata);
		is_create   = (req_q.func == FUNC_CREATE);
		is_lookup   = (req_q.func == FUNC_CHECK) || (req_q.func == FUNC_DESTROY);
		cur_valid   = slot_valid_q[idx_s1];
		cur_expired = req_q.now > ent_rd.expiry;
		cur_live    = cur_valid && !cur_expired;
		take_free   = scan_proc && is_create && !cur_live && !free_found_q;
		take_min    = scan_proc && is_create && cur_live &&
		              (!min_found_q || (ent_rd.expiry < min_exp_q));
		take_match  = scan_proc && is_lookup && cur_valid && !hit_q &&
		              (ent_rd.token_hi == req_q.token_hi) &&
		              (ent_rd.token_lo == req_q.token_lo);
	end

	// Write-back decision, used in the write state only.
	always_comb begin
		pick      = free_found_q ? free_idx_q : min_idx_q;
		m_expired = req_q.now > m_exp_q;
		ram_we    = 1'b0;
		ram_waddr = pick;
		ram_wdata = '{token_hi: req_q.token_hi, token_lo: req_q.token_lo,
		              role: req_q.new_role, expiry: fresh_q};
		wr_set    = 1'b0;
		wr_clr    = 1'b0;
		wr_idx    = pick;
		res_d     = '0;
		case (req_q.func)
			FUNC_CREATE: begin
				ram_we           = 1'b1;
				wr_set           = 1'b1;
				res_d.slot_index = SLOT_IDX_W'(pick);
				res_d.evicted    = !free_found_q;
			end
			FUNC_CHECK: begin
				ram_waddr      = m_idx_q;
				ram_wdata.role = m_role_q;
				wr_idx         = m_idx_q;
				if (hit_q) begin
					res_d.hit        = 1'b1;
					res_d.slot_index = SLOT_IDX_W'(m_idx_q);
					if (m_expired) begin
						wr_clr = 1'b1;
					end else begin
						ram_we         = 1'b1;
						res_d.role_out = m_role_q;
					end
				end
				res_d.allowed = (res_d.role_out >= req_q.need_role);
			end
			FUNC_DESTROY: begin
				wr_idx = m_idx_q;
				if (hit_q) begin
					wr_clr           = 1'b1;
					res_d.hit        = 1'b1;
					res_d.slot_index = SLOT_IDX_W'(m_idx_q);
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		if (state_q != ST_WRITE) begin
			ram_we = 1'b0;
			wr_set = 1'b0;
			wr_clr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_cnt_q  <= '0;
			rd_vld_s1    <= 1'b0;
			slot_valid_q <= '0;
			free_found_q <= 1'b0;
			min_found_q  <= 1'b0;
			hit_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q      <= ST_SCAN;
						issue_cnt_q  <= '0;
						rd_vld_s1    <= 1'b0;
						free_found_q <= 1'b0;
						min_found_q  <= 1'b0;
						hit_q        <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issuing;
					if (issuing) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (scan_proc && is_create && cur_valid && cur_expired) begin
						slot_valid_q[idx_s1] <= 1'b0;
					end
					if (take_free) begin
						free_found_q <= 1'b1;
					end
					if (take_min) begin
						min_found_q <= 1'b1;
					end
					if (take_match) begin
						hit_q <= 1'b1;
					end
					if (scan_proc && (idx_s1 == IW'(SLOTS - 1))) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wr_set) begin
						slot_valid_q[wr_idx] <= 1'b1;
					end
					if (wr_clr) begin
						slot_valid_q[wr_idx] <= 1'b0;
					end
					res_q       <= res_d;
					res_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						res_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and scan payload; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			fresh_q <= req.now + timeout;
		end
		idx_s1 <= issue_cnt_q[IW-1:0];
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (take_min) begin
			min_idx_q <= idx_s1;
			min_exp_q <= ent_rd.expiry;
		end
		if (take_match) begin
			m_idx_q  <= idx_s1;
			m_exp_q  <= ent_rd.expiry;
			m_role_q <= ent_rd.role;
		end
	end

endmodule

>>> rtl/session_table_with_expiry.sv
// Session table with expiry: top level with timeout register and result register.
//
// Use: present a request on in_valid with func, now, token_hi/token_lo,
// new_role and need_role; it is taken at a rising edge with in_valid high and
// in_stall low. func selects create (store the token in the lowest free slot
// after dropping expired slots, or evict the slot with the smallest expiry),
// check (look the token up, refresh or drop it, report its role) or destroy.
// Exactly one result leaves on out_valid for every request, in order.
// The scan reads one slot a cycle through the single read port of the entry
// memory; a write-back state and the hand-over follow it.
// One request is in work at a time; in_stall is high while it is.
// A finished result waits in the output register while out_stall is high;
// the next request is still taken and scanned, and its hand-over holds until
// the output register frees.
// Reset clears every slot valid bit, empties the pipeline and loads the
// timeout register with 1800000 ticks; no memory clearing pass is run.
// timeout_we/timeout_wdata write the session lifetime; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module session_table_with_expiry (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            timeout_we,
	input  logic [ste_pkg::TIME_W-1:0]      timeout_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ste_pkg::FUNC_W-1:0]      func,
	input  logic [ste_pkg::TIME_W-1:0]      now,
	input  logic [ste_pkg::TOKEN_W-1:0]     token_hi,
	input  logic [ste_pkg::TOKEN_W-1:0]     token_lo,
	input  logic [ste_pkg::ROLE_W-1:0]      new_role,
	input  logic [ste_pkg::ROLE_W-1:0]      need_role,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ste_pkg::ROLE_W-1:0]      role_out,
	output logic                            allowed,
	output logic                            hit,
	output logic [ste_pkg::SLOT_IDX_W-1:0]  slot_index,
	output logic                            evicted
);
	import ste_pkg::*;

	logic [TIME_W-1:0] timeout_q;
	req_t              req;
	logic              res_valid;
	res_t              res;
	logic              res_take;
	logic              out_valid_q;
	res_t              out_q;

	// Bundle the request fields for the sequencer.
	assign req = '{func: func, now: now, token_hi: token_hi, token_lo: token_lo,
	              new_role: new_role, need_role: need_role};

	// Take a finished result whenever the output register is empty or draining.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	ste_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req       (req),
		.timeout   (timeout_q),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// Hold the session lifetime.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	// Output register: load on take, drop valid once the receiver has it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign role_out   = out_q.role_out;
	assign allowed    = out_q.allowed;
	assign hit        = out_q.hit;
	assign slot_index = out_q.slot_index;
	assign evicted    = out_q.evicted;

endmodule
